/* design/odpi_pkg.sv */
// ----------------------------------------------------------------------------
// odpi_pkg
// Shared types, codes and sizes for the ordered deque with positional insert.
// ----------------------------------------------------------------------------
package odpi_pkg;

  localparam int DEPTH  = 32;
  localparam int CW     = $clog2(DEPTH + 1);           // element count width
  localparam int IW     = $clog2(DEPTH);               // cell index width
  localparam int POS_W  = 6;
  localparam int CMPW   = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int IN_W   = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W  = ((VAL_W + STAT_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST_FWD  = 3'd5;
  localparam logic [OP_W-1:0] OP_LIST_BWD  = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept_op;   // perform a non-listing op or an empty listing, load its status result
    logic list_start;  // latch direction, clear the listing index
    logic list_step;   // load the next listed element
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_list;     // incoming op is a listing
    logic empty;       // no elements held
    logic list_last;   // current listing index is the final element
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage

/* design/odpi_datapath.sv */
// ----------------------------------------------------------------------------
// odpi_datapath
// Cell row, element count, listing index and output register.
// ----------------------------------------------------------------------------
module odpi_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [odpi_pkg::OP_W-1:0]    op,
  input  logic [odpi_pkg::IN_W-1:0]    in_data,
  input  odpi_pkg::cmd_t               cmd,
  output odpi_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [odpi_pkg::OUT_W-1:0]   out_data,
  output logic                         out_last
);

  logic [odpi_pkg::VAL_W-1:0]  cells [odpi_pkg::DEPTH];
  logic [odpi_pkg::CW-1:0]     count;
  logic [odpi_pkg::IW-1:0]     list_idx;
  logic                        list_fwd;
  logic [odpi_pkg::VAL_W-1:0]  out_element;
  logic [odpi_pkg::STAT_W-1:0] out_status;

  logic [odpi_pkg::VAL_W-1:0]  value;
  logic [odpi_pkg::POS_W-1:0]  position;
  logic [odpi_pkg::CMPW-1:0]   pos_c;
  logic [odpi_pkg::CMPW-1:0]   cnt_c;
  logic [odpi_pkg::CMPW-1:0]   pos_m1;
  logic                        full;
  logic                        empty;
  logic                        bad_pos;
  logic [odpi_pkg::CW-1:0]     slot;
  logic [odpi_pkg::STAT_W-1:0] op_status;
  logic                        do_insert;
  logic                        do_del_front;
  logic                        do_del_end;
  logic [odpi_pkg::CW-1:0]     rev_idx;
  logic [odpi_pkg::IW-1:0]     rd_idx;

  assign value    = in_data[odpi_pkg::VAL_W-1:0];
  assign position = in_data[odpi_pkg::VAL_W +: odpi_pkg::POS_W];
  assign pos_c    = odpi_pkg::CMPW'(position);
  assign cnt_c    = odpi_pkg::CMPW'(count);
  assign pos_m1   = pos_c - odpi_pkg::CMPW'(1);
  assign full     = (count == odpi_pkg::CW'(odpi_pkg::DEPTH));
  assign empty    = (count == '0);
  assign bad_pos  = (pos_c == '0) || (pos_c > cnt_c + odpi_pkg::CMPW'(1));

  always_comb begin
    slot      = '0;
    op_status = odpi_pkg::ST_OK;
    case (op)
      odpi_pkg::OP_INS_FRONT: begin
        slot = '0;
        if (full) op_status = odpi_pkg::ST_FULL;
      end
      odpi_pkg::OP_INS_END: begin
        slot = count;
        if (full) op_status = odpi_pkg::ST_FULL;
      end
      odpi_pkg::OP_INS_POS: begin
        slot = pos_m1[odpi_pkg::CW-1:0];
        if (full) op_status = odpi_pkg::ST_FULL;
        else if (bad_pos) op_status = odpi_pkg::ST_BADPOS;
      end
      odpi_pkg::OP_DEL_FRONT, odpi_pkg::OP_DEL_END,
      odpi_pkg::OP_LIST_FWD, odpi_pkg::OP_LIST_BWD: begin
        if (empty) op_status = odpi_pkg::ST_EMPTY;
      end
      default: begin
        op_status = odpi_pkg::ST_OK;
      end
    endcase
  end

  assign do_insert    = cmd.accept_op && (op_status == odpi_pkg::ST_OK) &&
                        (op inside {odpi_pkg::OP_INS_FRONT, odpi_pkg::OP_INS_END,
                                    odpi_pkg::OP_INS_POS});
  assign do_del_front = cmd.accept_op && !empty && (op == odpi_pkg::OP_DEL_FRONT);
  assign do_del_end   = cmd.accept_op && !empty && (op == odpi_pkg::OP_DEL_END);

  // listing read address, front to back or back to front
  assign rev_idx = count - odpi_pkg::CW'(1) - odpi_pkg::CW'(list_idx);
  assign rd_idx  = list_fwd ? list_idx : rev_idx[odpi_pkg::IW-1:0];

  assign stat.is_list   = (op == odpi_pkg::OP_LIST_FWD) || (op == odpi_pkg::OP_LIST_BWD);
  assign stat.empty     = empty;
  assign stat.list_last = (odpi_pkg::CW'(list_idx) == count - odpi_pkg::CW'(1));
  assign stat.out_free  = !out_valid || out_ready;

  // cell row: shift up behind the insert slot, shift down on front delete
  always_ff @(posedge clk) begin
    if (do_insert) begin
      if (slot == '0) cells[0] <= value;
      for (int i = 1; i < odpi_pkg::DEPTH; i++) begin
        if (odpi_pkg::CW'(i) > slot) cells[i] <= cells[i-1];
        else if (odpi_pkg::CW'(i) == slot) cells[i] <= value;
      end
    end else if (do_del_front) begin
      for (int i = 0; i < odpi_pkg::DEPTH - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + odpi_pkg::CW'(1);
    end else if (do_del_front || do_del_end) begin
      count <= count - odpi_pkg::CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      list_idx <= '0;
      list_fwd <= (op == odpi_pkg::OP_LIST_FWD);
    end else if (cmd.list_step) begin
      list_idx <= list_idx + odpi_pkg::IW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept_op || cmd.list_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_op) begin
      out_element <= '0;
      out_status  <= op_status;
      out_last    <= 1'b1;
    end else if (cmd.list_step) begin
      out_element <= cells[rd_idx];
      out_status  <= odpi_pkg::ST_OK;
      out_last    <= stat.list_last;
    end
  end

  assign out_data = odpi_pkg::OUT_W'({out_status, out_element});

endmodule

/* design/odpi_ctrl.sv */
// ----------------------------------------------------------------------------
// odpi_ctrl
// Controller: takes one transaction at a time and walks listings.
// ----------------------------------------------------------------------------
module odpi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  odpi_pkg::stat_t stat,
  output odpi_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd.accept_op  = 1'b0;
    cmd.list_start = 1'b0;
    cmd.list_step  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.is_list && !stat.empty) begin
            cmd.list_start = 1'b1;
            state_next     = S_LIST;
          end else begin
            cmd.accept_op = 1'b1;
          end
        end
      end
      S_LIST: begin
        // hold the input until the final element is loaded
        if (stat.out_free) begin
          cmd.list_step = 1'b1;
          if (stat.list_last) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/ordered_deque_with_positional_insert.sv */
// ----------------------------------------------------------------------------
// ordered_deque_with_positional_insert
// Holds up to 32 signed 32-bit values in order; inserts at the front, end or
// a 1-based position, deletes at either end, and lists the contents.
// ----------------------------------------------------------------------------
// Each transaction on the s_ side is one operation. Inserts and front deletes
// shift the register row of cells, an end delete only lowers the count, and
// each gives one status result; a new one can follow while the m_ side keeps
// up. A listing holds the input while it runs a start step and then loads one
// element per cycle while the m_ side keeps up, set by the single read port of
// the cell row; an empty listing answers at once with status empty. The final
// result of every operation has m_tlast high. No clearing pass follows reset.
module ordered_deque_with_positional_insert (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [odpi_pkg::IN_W-1:0]    s_tdata,   // value[31:0], position[37:32], zero pad
  input  logic [odpi_pkg::OP_W-1:0]    s_tuser,   // op[2:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [odpi_pkg::OUT_W-1:0]   m_tdata,   // element[31:0], status[33:32], zero pad
  output logic                         m_tlast
);

  odpi_pkg::cmd_t  cmd;
  odpi_pkg::stat_t stat;

  odpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  odpi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
